### src/prt_pkg.sv
// Package for the pending request table: field widths, action and status
// codes and the sequencer state type. No dependencies.
package prt_pkg;

  localparam int unsigned ACTION_W      = 2;
  localparam int unsigned ID_W          = 64;
  localparam int unsigned TMPL_W        = 64;
  localparam int unsigned HANDLE_PORT_W = 16;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TAKE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_HANDLE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_WRITE  = 6'b010000,
    S_DONE   = 6'b100000
  } prt_state_e;

endpackage

### src/prt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stands alone; the pending request table keeps its entries in it.
module prt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/pending_request_table_with_eviction.sv
// Pending request table with oldest-first eviction: top level.
// Depends on prt_pkg (codes, widths, state type) and prt_ram (entry store).
//
// Usage. One beat on the input channel (in_valid_i / in_stall_o) carries an
// action: add an entry, take an entry by id, or remove an entry by id. Every
// input beat yields exactly one beat on the output channel (out_valid_o /
// out_stall_i) with a status, the contents of a taken entry and, for an add
// into a full table, the id and handle of the evicted oldest entry.
// The entries live in one synchronous RAM, one word per slot holding the id,
// kind, template, handle and the slot's position in arrival order (0 is the
// oldest). Valid bits and the occupancy count are flip-flops.
// Sequence. Each beat first sweeps all TABLE_DEPTH slots through the RAM read
// port to find the id and the oldest entry, then takes a decision step. A
// take, a remove or an eviction sweeps the table again with read-modify-write
// to close the gap in arrival order. An add ends with a write of the new
// entry, and a final step loads the output register. The single RAM read port
// sets the pace; one beat is in work at a time and the next one is taken only
// after the last one has loaded the output register.
// in_stall_o is high while a beat is in work. The output register keeps a
// finished result while the receiver stalls; the next input beat is taken
// meanwhile and only waits for the register at its end.
// Reset clears all valid bits and the occupancy at once; no clearing pass.
module pending_request_table_with_eviction #(
  parameter int unsigned TABLE_DEPTH = 50,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [prt_pkg::ACTION_W-1:0]        action_i,
  input  logic [prt_pkg::ID_W-1:0]            request_id_i,
  input  logic                                command_kind_i,
  input  logic [prt_pkg::TMPL_W-1:0]          template_ref_i,
  input  logic [prt_pkg::HANDLE_PORT_W-1:0]   completion_handle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [prt_pkg::STATUS_W-1:0]        status_o,
  output logic                                found_kind_o,
  output logic [prt_pkg::TMPL_W-1:0]          found_template_o,
  output logic [prt_pkg::HANDLE_PORT_W-1:0]   found_handle_o,
  output logic                                evicted_o,
  output logic [prt_pkg::ID_W-1:0]            evicted_id_o,
  output logic [prt_pkg::HANDLE_PORT_W-1:0]   evicted_handle_o
);

  // Slot address and arrival rank share one width; the counter can also
  // hold TABLE_DEPTH itself, which marks the end of a sweep.
  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  // Only the low HANDLE_BITS bits of a handle count, and never more than
  // the port carries.
  localparam int unsigned HandleW = (HANDLE_BITS < prt_pkg::HANDLE_PORT_W) ?
                                    HANDLE_BITS : prt_pkg::HANDLE_PORT_W;

  typedef struct packed {
    logic [prt_pkg::ID_W-1:0]   id;
    logic                       kind;
    logic [prt_pkg::TMPL_W-1:0] tmpl;
    logic [HandleW-1:0]         hdl;
    logic [AddrW-1:0]           rank;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  prt_pkg::prt_state_e state_q, state_d;

  // Table bookkeeping.
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CntW-1:0]        occ_q;

  // Sweep sequencing: address issued this cycle, and the slot whose data
  // the RAM returns in this cycle.
  logic [CntW-1:0]  rd_addr_q;
  logic             rd_pend_q;
  logic [AddrW-1:0] rd_slot_q;

  // The beat in work.
  logic [prt_pkg::ACTION_W-1:0] act_q;
  logic [prt_pkg::ID_W-1:0]     id_q;
  logic                         kind_q;
  logic [prt_pkg::TMPL_W-1:0]   tmpl_q;
  logic [HandleW-1:0]           hdl_q;

  // What the search sweep found: the entry with the id, and the oldest one.
  logic                       hit_q;
  logic [AddrW-1:0]           hit_slot_q;
  logic [AddrW-1:0]           hit_rank_q;
  logic                       hit_kind_q;
  logic [prt_pkg::TMPL_W-1:0] hit_tmpl_q;
  logic [HandleW-1:0]         hit_hdl_q;
  logic                       old_q;
  logic [AddrW-1:0]           old_slot_q;
  logic [prt_pkg::ID_W-1:0]   old_id_q;
  logic [HandleW-1:0]         old_hdl_q;

  // Decision taken after the search.
  logic [prt_pkg::STATUS_W-1:0] res_status_q;
  logic                         res_found_q;
  logic                         res_ev_q;
  logic                         wr_pend_q;
  logic [AddrW-1:0]             drop_rank_q;

  // Output register.
  logic                              out_valid_q;
  logic [prt_pkg::STATUS_W-1:0]      out_status_q;
  logic                              out_kind_q;
  logic [prt_pkg::TMPL_W-1:0]        out_tmpl_q;
  logic [prt_pkg::HANDLE_PORT_W-1:0] out_hdl_q;
  logic                              out_ev_q;
  logic [prt_pkg::ID_W-1:0]          out_ev_id_q;
  logic [prt_pkg::HANDLE_PORT_W-1:0] out_ev_hdl_q;

  // RAM ports.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  logic                         in_accept;
  logic                         sweep_done;
  logic                         rd_slot_valid;
  logic                         scan_hit;
  logic                         scan_old;
  logic                         shift_we;
  logic                         is_add;
  logic                         is_take;
  logic                         is_remove;
  logic                         full;
  logic                         add_ok;
  logic                         do_evict;
  logic                         do_drop_hit;
  logic                         dec_write;
  logic [prt_pkg::STATUS_W-1:0] dec_status;
  logic [AddrW-1:0]             free_slot;
  logic                         load_out;

  assign in_stall_o = (state_q != prt_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign sweep_done    = (rd_addr_q == CntW'(TABLE_DEPTH)) && !rd_pend_q;
  assign rd_slot_valid = rd_pend_q && valid_q[rd_slot_q];

  assign scan_hit = (state_q == prt_pkg::S_SCAN) && rd_slot_valid &&
                    (ram_rdata.id == id_q);
  assign scan_old = (state_q == prt_pkg::S_SCAN) && rd_slot_valid &&
                    (ram_rdata.rank == '0);
  // Closing the gap: every live entry younger than the dropped one moves
  // one place toward the head.
  assign shift_we = (state_q == prt_pkg::S_SHIFT) && rd_slot_valid &&
                    (ram_rdata.rank > drop_rank_q);

  assign is_add    = (act_q == prt_pkg::ACT_ADD);
  assign is_take   = (act_q == prt_pkg::ACT_TAKE);
  assign is_remove = (act_q == prt_pkg::ACT_REMOVE);
  assign full      = (occ_q == CntW'(TABLE_DEPTH));

  // An add goes ahead only with a handle and an id not yet present. The
  // zero-handle check comes first.
  assign add_ok      = is_add && (hdl_q != '0) && !hit_q;
  assign do_evict    = add_ok && full && old_q;
  assign do_drop_hit = (is_take || is_remove) && hit_q;
  assign dec_write   = add_ok && (!full || old_q);

  always_comb begin
    dec_status = prt_pkg::ST_OK;
    if (is_add) begin
      if (hdl_q == '0) begin
        dec_status = prt_pkg::ST_NO_HANDLE;
      end else if (hit_q) begin
        dec_status = prt_pkg::ST_DUPLICATE;
      end
    end else if (is_take || is_remove) begin
      if (!hit_q) begin
        dec_status = prt_pkg::ST_NOT_FOUND;
      end
    end
  end

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = AddrW'(i);
      end
    end
  end

  assign load_out = (state_q == prt_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  // RAM write: either a rank update during the shift sweep, or the new entry.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_slot_q;
    ram_wdata = ram_rdata;
    if (state_q == prt_pkg::S_WRITE) begin
      ram_we         = 1'b1;
      ram_waddr      = free_slot;
      ram_wdata.id   = id_q;
      ram_wdata.kind = kind_q;
      ram_wdata.tmpl = tmpl_q;
      ram_wdata.hdl  = hdl_q;
      ram_wdata.rank = occ_q[AddrW-1:0];
    end else if (shift_we) begin
      ram_we         = 1'b1;
      ram_wdata.rank = ram_rdata.rank - AddrW'(1);
    end
  end

  prt_ram #(
    .WIDTH(EntryW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      prt_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = prt_pkg::S_SCAN;
        end
      end
      prt_pkg::S_SCAN: begin
        if (sweep_done) begin
          state_d = prt_pkg::S_DECIDE;
        end
      end
      prt_pkg::S_DECIDE: begin
        if (do_evict || do_drop_hit) begin
          state_d = prt_pkg::S_SHIFT;
        end else if (dec_write) begin
          state_d = prt_pkg::S_WRITE;
        end else begin
          state_d = prt_pkg::S_DONE;
        end
      end
      prt_pkg::S_SHIFT: begin
        if (sweep_done) begin
          state_d = wr_pend_q ? prt_pkg::S_WRITE : prt_pkg::S_DONE;
        end
      end
      prt_pkg::S_WRITE: begin
        state_d = prt_pkg::S_DONE;
      end
      prt_pkg::S_DONE: begin
        if (load_out) begin
          state_d = prt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = prt_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prt_pkg::S_IDLE;
      valid_q     <= '0;
      occ_q       <= '0;
      rd_addr_q   <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      old_q       <= 1'b0;
      res_found_q <= 1'b0;
      res_ev_q    <= 1'b0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        prt_pkg::S_IDLE: begin
          rd_addr_q <= '0;
          rd_pend_q <= 1'b0;
          hit_q     <= 1'b0;
          old_q     <= 1'b0;
        end
        prt_pkg::S_SCAN, prt_pkg::S_SHIFT: begin
          if (rd_addr_q != CntW'(TABLE_DEPTH)) begin
            rd_addr_q <= rd_addr_q + CntW'(1);
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
          end
          if (scan_hit) begin
            hit_q <= 1'b1;
          end
          if (scan_old) begin
            old_q <= 1'b1;
          end
        end
        prt_pkg::S_DECIDE: begin
          rd_addr_q   <= '0;
          rd_pend_q   <= 1'b0;
          res_found_q <= is_take && hit_q;
          res_ev_q    <= do_evict;
          wr_pend_q   <= dec_write;
          if (do_evict) begin
            valid_q[old_slot_q] <= 1'b0;
            occ_q               <= occ_q - CntW'(1);
          end else if (do_drop_hit) begin
            valid_q[hit_slot_q] <= 1'b0;
            occ_q               <= occ_q - CntW'(1);
          end
        end
        prt_pkg::S_WRITE: begin
          valid_q[free_slot] <= 1'b1;
          occ_q              <= occ_q + CntW'(1);
        end
        default: begin
        end
      endcase
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_slot_q <= rd_addr_q[AddrW-1:0];
    if (in_accept) begin
      act_q  <= action_i;
      id_q   <= request_id_i;
      kind_q <= command_kind_i;
      tmpl_q <= template_ref_i;
      hdl_q  <= completion_handle_i[HandleW-1:0];
    end
    if (scan_hit) begin
      hit_slot_q <= rd_slot_q;
      hit_rank_q <= ram_rdata.rank;
      hit_kind_q <= ram_rdata.kind;
      hit_tmpl_q <= ram_rdata.tmpl;
      hit_hdl_q  <= ram_rdata.hdl;
    end
    if (scan_old) begin
      old_slot_q <= rd_slot_q;
      old_id_q   <= ram_rdata.id;
      old_hdl_q  <= ram_rdata.hdl;
    end
    if (state_q == prt_pkg::S_DECIDE) begin
      res_status_q <= dec_status;
      // An eviction always drops the head of the arrival order.
      drop_rank_q  <= do_evict ? '0 : hit_rank_q;
    end
    if (load_out) begin
      out_status_q <= res_status_q;
      out_kind_q   <= res_found_q ? hit_kind_q : 1'b0;
      out_tmpl_q   <= res_found_q ? hit_tmpl_q : '0;
      out_hdl_q    <= res_found_q ? prt_pkg::HANDLE_PORT_W'(hit_hdl_q) : '0;
      out_ev_q     <= res_ev_q;
      out_ev_id_q  <= res_ev_q ? old_id_q : '0;
      out_ev_hdl_q <= res_ev_q ? prt_pkg::HANDLE_PORT_W'(old_hdl_q) : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_kind_o     = out_kind_q;
  assign found_template_o = out_tmpl_q;
  assign found_handle_o   = out_hdl_q;
  assign evicted_o        = out_ev_q;
  assign evicted_id_o     = out_ev_id_q;
  assign evicted_handle_o = out_ev_hdl_q;

  // The occupancy count always agrees with the valid bits.
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy count disagrees with valid bits");

  // A new entry is only written when a free slot exists.
  a_write_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prt_pkg::S_WRITE) |-> (occ_q < CntW'(TABLE_DEPTH)))
    else $error("entry write into a full table");

  // The search sweep never modifies the table store.
  a_scan_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prt_pkg::S_SCAN) |-> !ram_we)
    else $error("RAM written during search sweep");

endmodule
